/* rtl/adw_pkg.sv */
// shared constants and cell word types for the adam weight update pipeline
package adw_pkg;

    localparam int DW = 32;                 // data field width
    localparam int FB = 24;                 // fraction bits
    localparam int WDW = 16;                // weight decay width
    localparam int RW = 28;                 // square root result width
    localparam int QW = 34;                 // quotient bits before clamping
    localparam int PW = 64;                 // step product width
    localparam int IDXW = 2;                // config index width

    localparam logic [IDXW-1:0] REG_STEP_SIZE = 2'd0;
    localparam logic [IDXW-1:0] REG_DECAY_COEF = 2'd1;

    localparam logic signed [29:0] COEF_M = 30'sd429496730;   // 0.1 in q0.32
    localparam logic signed [23:0] COEF_V = 24'sd4294967;     // 0.001 in q0.32

    typedef struct packed {
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] mn;
        logic [DW-1:0]        vn;
        logic                 last;
        logic                 sat;
    } t_side;

    typedef struct packed {
        logic [2*RW-1:0] x;
        logic [RW+1:0]   rem;
        logic [RW-1:0]   root;
        logic [PW-1:0]   prods;
        t_side           side;
    } t_sq;

    typedef struct packed {
        logic [RW:0]   d;
        logic [RW:0]   rem;
        logic [QW-1:0] nq;
        logic          ovf;
        t_side         side;
    } t_dv;

endpackage

/* rtl/adw_in_if.sv */
// input channel: one parameter element with its gradient and moments
interface adw_in_if;
    import adw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] weight;
    logic signed [DW-1:0] gradient;
    logic signed [DW-1:0] first_moment;
    logic [DW-1:0]        second_moment;
    logic                 last_element;

    modport source (output valid, weight, gradient, first_moment, second_moment,
                    last_element, input ready);
    modport sink (input valid, weight, gradient, first_moment, second_moment,
                  last_element, output ready);
endinterface

/* rtl/adw_out_if.sv */
// output channel: updated weight and moments
interface adw_out_if;
    import adw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] new_weight;
    logic signed [DW-1:0] new_first_moment;
    logic [DW-1:0]        new_second_moment;
    logic                 last_out;
    logic                 saturated;

    modport source (output valid, new_weight, new_first_moment, new_second_moment,
                    last_out, saturated, input ready);
    modport sink (input valid, new_weight, new_first_moment, new_second_moment,
                  last_out, saturated, output ready);
endinterface

/* rtl/adw_front.sv */
// front pipeline: weight decay, moment updates and step product
module adw_front
    import adw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_weight,
    input  logic signed [DW-1:0] i_gradient,
    input  logic signed [DW-1:0] i_first_moment,
    input  logic [DW-1:0]        i_second_moment,
    input  logic                 i_last_element,
    input  logic [DW-1:0]        i_step_size,
    input  logic [WDW-1:0]       i_decay_coef,
    output logic                 o_valid,
    output t_sq                  o_sq
);

    logic [6:0] r_vld;

    // stage a
    logic signed [47:0]   r_a_p;
    logic signed [DW-1:0] r_a_w, r_a_g, r_a_m;
    logic [DW-1:0]        r_a_v;
    logic                 r_a_last;
    // stage b
    logic signed [34:0]   r_b_diff;
    logic [DW-1:0]        r_b_gmag;
    logic signed [DW-1:0] r_b_w, r_b_m;
    logic [DW-1:0]        r_b_v;
    logic                 r_b_last;
    // stage c
    logic signed [63:0]   r_c_prodm;
    logic [63:0]          r_c_sqr;
    logic signed [DW-1:0] r_c_w, r_c_m;
    logic [DW-1:0]        r_c_v;
    logic                 r_c_last;
    // stage d
    logic signed [DW-1:0] r_d_mn;
    logic                 r_d_sat;
    logic [40:0]          r_d_s;
    logic signed [DW-1:0] r_d_w;
    logic [DW-1:0]        r_d_v;
    logic                 r_d_last;
    // stage e
    logic signed [41:0]   r_e_dv;
    logic [DW-1:0]        r_e_mmag;
    logic signed [DW-1:0] r_e_w, r_e_mn;
    logic [DW-1:0]        r_e_v;
    logic                 r_e_last, r_e_sat;
    // stage f
    logic signed [65:0]   r_f_prodv;
    logic [PW-1:0]        r_f_prods;
    logic signed [DW-1:0] r_f_w, r_f_mn;
    logic [DW-1:0]        r_f_v;
    logic                 r_f_last, r_f_sat;
    // stage g
    t_sq                  r_g;

    logic signed [47:0] n_a_p;
    logic signed [32:0] n_b_decay;
    logic signed [33:0] n_b_grad;
    logic [33:0]        n_b_gabs;
    logic signed [64:0] n_d_rm;
    logic signed [33:0] n_d_mn;
    logic [64:0]        n_d_rs;
    logic signed [66:0] n_g_rv;
    logic signed [34:0] n_g_vn;
    logic [DW-1:0]      n_g_vc;
    logic               n_g_sat;
    logic [DW:0]        n_e_mabs;

    always_comb begin
        n_a_p = $signed({1'b0, i_decay_coef}) * i_weight;

        n_b_decay = 33'((r_a_p + 48'sd32768) >>> 16);
        n_b_grad = 34'(r_a_g) + 34'(n_b_decay);
        n_b_gabs = n_b_grad[33] ? 34'(-n_b_grad) : n_b_grad;

        n_d_rm = 65'(r_c_prodm) + 65'sh80000000;
        n_d_mn = 34'(r_c_m) + 34'(n_d_rm >>> 32);
        n_d_rs = 65'(r_c_sqr) + 65'h800000;

        n_e_mabs = r_d_mn[DW-1] ? 33'(-34'(r_d_mn)) : {1'b0, r_d_mn};

        n_g_rv = 67'(r_f_prodv) + 67'sh80000000;
        n_g_vn = 35'($signed({1'b0, r_f_v})) + 35'(n_g_rv >>> 32);
        n_g_sat = r_f_sat;
        if (n_g_vn < 0) begin
            n_g_vc = '0;
            n_g_sat = 1'b1;
        end else if (n_g_vn[34:32] != 3'd0) begin
            n_g_vc = '1;
            n_g_sat = 1'b1;
        end else begin
            n_g_vc = n_g_vn[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_p    <= n_a_p;
            r_a_w    <= i_weight;
            r_a_g    <= i_gradient;
            r_a_m    <= i_first_moment;
            r_a_v    <= i_second_moment;
            r_a_last <= i_last_element;

            r_b_diff <= 35'(n_b_grad) - 35'(r_a_m);
            r_b_gmag <= n_b_gabs[DW-1:0];
            r_b_w    <= r_a_w;
            r_b_m    <= r_a_m;
            r_b_v    <= r_a_v;
            r_b_last <= r_a_last;

            r_c_prodm <= 64'(r_b_diff * COEF_M);
            r_c_sqr   <= r_b_gmag * r_b_gmag;
            r_c_w     <= r_b_w;
            r_c_m     <= r_b_m;
            r_c_v     <= r_b_v;
            r_c_last  <= r_b_last;

            // clamp the new first moment to the signed range
            if (n_d_mn > 34'sh7FFFFFFF) begin
                r_d_mn  <= 32'sh7FFFFFFF;
                r_d_sat <= 1'b1;
            end else if (n_d_mn < -34'sh80000000) begin
                r_d_mn  <= 32'sh80000000;
                r_d_sat <= 1'b1;
            end else begin
                r_d_mn  <= n_d_mn[DW-1:0];
                r_d_sat <= 1'b0;
            end
            r_d_s    <= n_d_rs[64:FB];
            r_d_w    <= r_c_w;
            r_d_v    <= r_c_v;
            r_d_last <= r_c_last;

            r_e_dv   <= $signed({1'b0, r_d_s}) - $signed({10'd0, r_d_v});
            r_e_mmag <= n_e_mabs[DW-1:0];
            r_e_w    <= r_d_w;
            r_e_mn   <= r_d_mn;
            r_e_v    <= r_d_v;
            r_e_last <= r_d_last;
            r_e_sat  <= r_d_sat;

            r_f_prodv <= r_e_dv * COEF_V;
            r_f_prods <= i_step_size * r_e_mmag;
            r_f_w     <= r_e_w;
            r_f_mn    <= r_e_mn;
            r_f_v     <= r_e_v;
            r_f_last  <= r_e_last;
            r_f_sat   <= r_e_sat;

            r_g.x         <= {n_g_vc, {FB{1'b0}}};
            r_g.rem       <= '0;
            r_g.root      <= '0;
            r_g.prods     <= r_f_prods;
            r_g.side.w    <= r_f_w;
            r_g.side.mn   <= r_f_mn;
            r_g.side.vn   <= n_g_vc;
            r_g.side.last <= r_f_last;
            r_g.side.sat  <= n_g_sat;
        end
    end

    assign o_valid = r_vld[6];
    assign o_sq = r_g;

endmodule

/* rtl/adw_sqrt_cell.sv */
// square root cell: settles one root bit from two radicand bits
module adw_sqrt_cell
    import adw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_sq  i_sq,
    output logic o_valid,
    output t_sq  o_sq
);

    logic        r_valid;
    t_sq         r_sq;
    t_sq         n_sq;
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;

    always_comb begin
        n_sq = i_sq;
        cur = {i_sq.rem, i_sq.x[2*RW-1 -: 2]};
        trial = {2'b00, i_sq.root, 2'b01};
        n_sq.x = {i_sq.x[2*RW-3:0], 2'b00};
        if (cur >= trial) begin
            n_sq.rem = (RW+2)'(cur - trial);
            n_sq.root = {i_sq.root[RW-2:0], 1'b1};
        end else begin
            n_sq.rem = cur[RW+1:0];
            n_sq.root = {i_sq.root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_sq = r_sq;

endmodule

/* rtl/adw_div_cell.sv */
// divider cell: one restoring quotient bit per cell
module adw_div_cell
    import adw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_dv  i_dv,
    output logic o_valid,
    output t_dv  o_dv
);

    logic        r_valid;
    t_dv         r_dv;
    t_dv         n_dv;
    logic [RW+1:0] cur;

    always_comb begin
        n_dv = i_dv;
        cur = {i_dv.rem, i_dv.nq[QW-1]};
        // dividend bits leave the top of nq while quotient bits enter below
        if (cur >= {1'b0, i_dv.d}) begin
            n_dv.rem = (RW+1)'(cur - {1'b0, i_dv.d});
            n_dv.nq = {i_dv.nq[QW-2:0], 1'b1};
        end else begin
            n_dv.rem = cur[RW:0];
            n_dv.nq = {i_dv.nq[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv <= n_dv;
        end
    end

    assign o_valid = r_valid;
    assign o_dv = r_dv;

endmodule

/* rtl/adam_weight_update.sv */
// adam weight update top level: front pipeline, root and divider cell rows
//
//   channel   dir   handshake      word
//   i_in      in    valid/ready    weight, gradient, first/second moment, last
//   o_out     out   valid/ready    new weight, new moments, last, saturated
//   i_cfg_*   in    write enable   step size (index 0), decay coefficient (index 1)
//
// one word per cycle while the output is not stalled; the path runs through 7 front
// stages, 28 root cells, 2 divisor stages, 34 divider cells and the output register.
// synchronous active-low reset clears the valid bits and both registers.
// a result waiting at the output stalls the whole pipeline in place; i_in.ready
// is low only while the output register holds an untaken word.
module adam_weight_update
    import adw_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [IDXW-1:0] i_cfg_idx,
    input  logic [DW-1:0]   i_cfg_data,
    adw_in_if.sink          i_in,
    adw_out_if.source       o_out
);

    logic [DW-1:0]  r_step_size;
    logic [WDW-1:0] r_decay_coef;
    logic           en;

    logic sq_v [0:RW];
    t_sq  sq_d [0:RW];
    logic dv_v [0:QW];
    t_dv  dv_d [0:QW];

    logic          r_h_valid;
    logic [RW:0]   r_h_d;
    logic [PW-1:0] r_h_n;
    t_side         r_h_side;
    logic          r_i_valid;
    t_dv           r_i;

    logic                 r_out_valid;
    logic signed [DW-1:0] r_nw, r_nm;
    logic [DW-1:0]        r_nv;
    logic                 r_last, r_sat;

    logic [QW:0]        n_q;
    logic signed [35:0] n_wn;
    t_dv                fin;

    assign en = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size  <= '0;
            r_decay_coef <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STEP_SIZE:  r_step_size <= i_cfg_data;
                REG_DECAY_COEF: r_decay_coef <= i_cfg_data[WDW-1:0];
                default:        ;
            endcase
        end
    end

    adw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_in.valid),
        .i_weight        (i_in.weight),
        .i_gradient      (i_in.gradient),
        .i_first_moment  (i_in.first_moment),
        .i_second_moment (i_in.second_moment),
        .i_last_element  (i_in.last_element),
        .i_step_size     (r_step_size),
        .i_decay_coef    (r_decay_coef),
        .o_valid         (sq_v[0]),
        .o_sq            (sq_d[0])
    );

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        adw_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[k]),
            .i_sq    (sq_d[k]),
            .o_valid (sq_v[k+1]),
            .o_sq    (sq_d[k+1])
        );
    end

    // divisor is root plus one lsb; numerator gets half the divisor for rounding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
        end else if (en) begin
            r_h_valid <= sq_v[RW];
            r_i_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_d    <= {1'b0, sq_d[RW].root} + (RW+1)'(1);
            r_h_n    <= sq_d[RW].prods + PW'(sq_d[RW].root[RW-1:0] + RW'(1)) / 2;
            r_h_side <= sq_d[RW].side;

            // quotient at or beyond 2^34 always drives the weight to a rail
            r_i.ovf  <= {1'b0, r_h_n[PW-1:QW]} >= {2'b00, r_h_d};
            r_i.rem  <= r_h_n[QW+RW:QW];
            r_i.nq   <= r_h_n[QW-1:0];
            r_i.d    <= r_h_d;
            r_i.side <= r_h_side;
        end
    end

    assign dv_v[0] = r_i_valid;
    assign dv_d[0] = r_i;

    for (genvar k = 0; k < QW; k++) begin : g_div
        adw_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[k]),
            .i_dv    (dv_d[k]),
            .o_valid (dv_v[k+1]),
            .o_dv    (dv_d[k+1])
        );
    end

    always_comb begin
        fin = dv_d[QW];
        n_q = fin.ovf ? {1'b1, {QW{1'b0}}} : {1'b0, fin.nq};
        if (fin.side.mn[DW-1]) begin
            n_wn = 36'(fin.side.w) + 36'($signed({1'b0, n_q}));
        end else begin
            n_wn = 36'(fin.side.w) - 36'($signed({1'b0, n_q}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nm   <= fin.side.mn;
            r_nv   <= fin.side.vn;
            r_last <= fin.side.last;
            if (n_wn > 36'sh7FFFFFFF) begin
                r_nw  <= 32'sh7FFFFFFF;
                r_sat <= 1'b1;
            end else if (n_wn < -36'sh80000000) begin
                r_nw  <= 32'sh80000000;
                r_sat <= 1'b1;
            end else begin
                r_nw  <= n_wn[DW-1:0];
                r_sat <= fin.side.sat;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.new_weight = r_nw;
    assign o_out.new_first_moment = r_nm;
    assign o_out.new_second_moment = r_nv;
    assign o_out.last_out = r_last;
    assign o_out.saturated = r_sat;

endmodule
